// ===== hw/rtl/lzw_stream_compressor_macros.svh =====
// Assertion helpers shared by the compressor modules.
`ifndef LZW_STREAM_COMPRESSOR_MACROS_SVH
`define LZW_STREAM_COMPRESSOR_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LZWC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lzwc check failed");

// Next-cycle implication, checked outside reset.
`define LZWC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lzwc check failed");

`endif

// ===== hw/rtl/lzwc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package lzwc_pkg;

    localparam int MAX_CODE_BITS_DEF = 15;
    localparam int CODE_FIELD_W      = 16;
    localparam int QUEUE_DEPTH       = 4;

    localparam logic [CODE_FIELD_W-1:0] CODE_STOP  = 16'h100;
    localparam logic [CODE_FIELD_W-1:0] CODE_GROW  = 16'h101;
    localparam logic [CODE_FIELD_W-1:0] CODE_FIRST = 16'h103;
    localparam logic [4:0]              START_WIDTH = 5'd9;

    typedef struct packed {
        logic [CODE_FIELD_W-1:0] value;
        logic [4:0]              width;
        logic                    last;
        logic                    is_end;
    } code_op_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_SRD,
        F_DRD,
        F_DCHK,
        F_MISS,
        F_CODE,
        F_END_CODE,
        F_END_STOP
    } front_state_t;

    typedef enum logic [1:0] {
        B_LOAD,
        B_DRAIN,
        B_FLUSH1,
        B_FLUSH2
    } back_state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/lzwc_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface lzwc_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] data_byte;

    modport source (output valid, command, data_byte, input ready);
    modport sink (input valid, command, data_byte, output ready);
endinterface

interface lzwc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       stream_done;

    modport source (output valid, out_byte, run_last, stream_done, input ready);
    modport sink (input valid, out_byte, run_last, stream_done, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/lzw_stream_compressor.sv =====
// LZW compressor with variable code width, 9 bits up to MAX_CODE_BITS, packing codes
// MSB first into bytes. A source byte whose first hash probe finds the string passes
// through the slot read, dictionary read and check states. A miss whose first slot is
// free skips the check; one whose slot holds a code from an earlier stream that still
// falls in the live code range makes the check first. Every further probe of the
// linear-probing hash slot memory reads the slot memory and then the dictionary memory
// in turn. The first byte of a stream is only stored, and end of stream sends the last
// code, if any, then the stop code. Behind a 4-entry code queue the packer loads a code
// and sends all its whole bytes before the next load; end of stream adds one or two
// flush bytes. A full queue stalls the front. No clearing pass is needed after reset:
// a slot counts only while its code is live in the current stream and the dictionary
// entry points back at that slot.
`timescale 1ns / 1ps
`default_nettype none
module lzw_stream_compressor #(
    parameter int MAX_CODE_BITS = lzwc_pkg::MAX_CODE_BITS_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    lzwc_in_if.sink    in_ch,
    lzwc_out_if.source out_ch
);

    lzwc_pkg::code_op_t push_op;
    lzwc_pkg::code_op_t pop_op;
    logic               push;
    logic               full;
    logic               pop;
    logic               empty;

    lzwc_front #(.MAX_CODE_BITS(MAX_CODE_BITS)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .op_valid (push),
        .op       (push_op),
        .op_full  (full)
    );

    lzwc_queue #(.DEPTH(lzwc_pkg::QUEUE_DEPTH)) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .full    (full),
        .pop     (pop),
        .pop_op  (pop_op),
        .empty   (empty)
    );

    lzwc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .op       (pop_op),
        .op_empty (empty),
        .op_pop   (pop),
        .out_ch   (out_ch)
    );

endmodule
`default_nettype wire

// ===== hw/rtl/lzwc_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module lzwc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== hw/rtl/lzwc_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "lzw_stream_compressor_macros.svh"
module lzwc_queue #(
    parameter int DEPTH = lzwc_pkg::QUEUE_DEPTH
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire lzwc_pkg::code_op_t push_op,
    output logic                    full,
    input  wire logic               pop,
    output lzwc_pkg::code_op_t      pop_op,
    output logic                    empty
);

    localparam int AW = $clog2(DEPTH);

    lzwc_pkg::code_op_t slot_reg [DEPTH];
    logic [AW-1:0] wr_reg, wr_next;
    logic [AW-1:0] rd_reg, rd_next;
    logic [AW:0]   cnt_reg, cnt_next;
    logic          do_push;
    logic          do_pop;

    assign full    = (cnt_reg == (AW+1)'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_op  = slot_reg[rd_reg];

    always_comb
    begin
        wr_next  = do_push ? AW'((AW+1)'(wr_reg) + 1'b1 == (AW+1)'(DEPTH) ? 0 : wr_reg + 1'b1)
                           : wr_reg;
        rd_next  = do_pop ? AW'((AW+1)'(rd_reg) + 1'b1 == (AW+1)'(DEPTH) ? 0 : rd_reg + 1'b1)
                          : rd_reg;
        cnt_next = cnt_reg + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_reg] <= push_op;
        end
    end

    `LZWC_ASSERT_NOW(a_no_push_when_full, clk, rst_n, push, !full)

endmodule
`default_nettype wire

// ===== hw/rtl/lzwc_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "lzw_stream_compressor_macros.svh"
module lzwc_front #(
    parameter int MAX_CODE_BITS = lzwc_pkg::MAX_CODE_BITS_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    lzwc_in_if.sink            in_ch,
    output logic               op_valid,
    output lzwc_pkg::code_op_t op,
    input  wire logic          op_full
);

    localparam int M  = MAX_CODE_BITS;
    localparam int HB = M + 1;
    localparam int DW = HB + M + 8;

    lzwc_pkg::front_state_t state_reg, state_next;
    logic [M-1:0]  current_reg, current_next;
    logic          empty_reg, empty_next;
    logic [M:0]    next_code_reg, next_code_next;
    logic [4:0]    width_reg, width_next;
    logic [7:0]    byte_reg, byte_next;
    logic [HB-1:0] h_reg, h_next;

    logic [M-1:0]  slot_q;
    logic [DW-1:0] dict_q;
    logic          slot_we;
    logic          dict_we;
    logic          in_range;
    logic          dict_free;
    logic          pow2;

    // A slot counts as taken only when its code is live and points back at it.
    assign in_range  = ({1'b0, slot_q} >= (M+1)'(lzwc_pkg::CODE_FIRST))
                    && ({1'b0, slot_q} < next_code_reg);
    assign dict_free = !next_code_reg[M];
    assign pow2      = ((next_code_reg & (next_code_reg - 1'b1)) == '0);

    lzwc_ram #(.WIDTH(M), .DEPTH(1 << HB)) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (h_reg),
        .wdata (next_code_reg[M-1:0]),
        .raddr (h_reg),
        .rdata (slot_q)
    );

    lzwc_ram #(.WIDTH(DW), .DEPTH(1 << M)) u_dict_ram (
        .clk   (clk),
        .we    (dict_we),
        .waddr (next_code_reg[M-1:0]),
        .wdata ({h_reg, current_reg, byte_reg}),
        .raddr (slot_q),
        .rdata (dict_q)
    );

    always_comb
    begin
        state_next     = state_reg;
        current_next   = current_reg;
        empty_next     = empty_reg;
        next_code_next = next_code_reg;
        width_next     = width_reg;
        byte_next      = byte_reg;
        h_next         = h_reg;
        in_ch.ready    = 1'b0;
        op_valid       = 1'b0;
        op             = '0;
        slot_we        = 1'b0;
        dict_we        = 1'b0;
        case (state_reg)
            lzwc_pkg::F_IDLE:
            begin
                in_ch.ready = 1'b1;
                if (in_ch.valid)
                begin
                    if (in_ch.command)
                    begin
                        state_next = empty_reg ? lzwc_pkg::F_END_STOP : lzwc_pkg::F_END_CODE;
                    end
                    else if (empty_reg)
                    begin
                        current_next = M'(in_ch.data_byte);
                        empty_next   = 1'b0;
                    end
                    else
                    begin
                        byte_next  = in_ch.data_byte;
                        h_next     = HB'(current_reg) ^ (HB'(in_ch.data_byte) << (HB - 8));
                        state_next = lzwc_pkg::F_SRD;
                    end
                end
            end
            lzwc_pkg::F_SRD:
            begin
                state_next = lzwc_pkg::F_DRD;
            end
            lzwc_pkg::F_DRD:
            begin
                state_next = in_range ? lzwc_pkg::F_DCHK : lzwc_pkg::F_MISS;
            end
            lzwc_pkg::F_DCHK:
            begin
                if (dict_q[DW-1 -: HB] != h_reg)
                begin
                    state_next = lzwc_pkg::F_MISS;
                end
                else if (dict_q[M+7:0] == {current_reg, byte_reg})
                begin
                    current_next = dict_q[M+7:8] == current_reg ? M'(slot_q) : M'(slot_q);
                    state_next   = lzwc_pkg::F_IDLE;
                end
                else
                begin
                    h_next     = h_reg + 1'b1;
                    state_next = lzwc_pkg::F_SRD;
                end
            end
            lzwc_pkg::F_MISS:
            begin
                if (dict_free && pow2)
                begin
                    op = '{value: lzwc_pkg::CODE_GROW, width: width_reg, last: 1'b0,
                           is_end: 1'b0};
                    if (!op_full)
                    begin
                        op_valid   = 1'b1;
                        width_next = width_reg + 1'b1;
                        state_next = lzwc_pkg::F_CODE;
                    end
                end
                else
                begin
                    state_next = lzwc_pkg::F_CODE;
                end
            end
            lzwc_pkg::F_CODE:
            begin
                op = '{value: lzwc_pkg::CODE_FIELD_W'(current_reg), width: width_reg,
                       last: 1'b1, is_end: 1'b0};
                if (!op_full)
                begin
                    op_valid     = 1'b1;
                    current_next = M'(byte_reg);
                    state_next   = lzwc_pkg::F_IDLE;
                    if (dict_free)
                    begin
                        slot_we        = 1'b1;
                        dict_we        = 1'b1;
                        next_code_next = next_code_reg + 1'b1;
                    end
                end
            end
            lzwc_pkg::F_END_CODE:
            begin
                op = '{value: lzwc_pkg::CODE_FIELD_W'(current_reg), width: width_reg,
                       last: 1'b0, is_end: 1'b0};
                if (!op_full)
                begin
                    op_valid   = 1'b1;
                    state_next = lzwc_pkg::F_END_STOP;
                end
            end
            lzwc_pkg::F_END_STOP:
            begin
                op = '{value: lzwc_pkg::CODE_STOP, width: width_reg, last: 1'b1,
                       is_end: 1'b1};
                if (!op_full)
                begin
                    op_valid       = 1'b1;
                    current_next   = '0;
                    empty_next     = 1'b1;
                    next_code_next = (M+1)'(lzwc_pkg::CODE_FIRST);
                    width_next     = lzwc_pkg::START_WIDTH;
                    state_next     = lzwc_pkg::F_IDLE;
                end
            end
            default:
            begin
                state_next = lzwc_pkg::F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lzwc_pkg::F_IDLE;
            current_reg   <= '0;
            empty_reg     <= 1'b1;
            next_code_reg <= (M+1)'(lzwc_pkg::CODE_FIRST);
            width_reg     <= lzwc_pkg::START_WIDTH;
        end
        else
        begin
            state_reg     <= state_next;
            current_reg   <= current_next;
            empty_reg     <= empty_next;
            next_code_reg <= next_code_next;
            width_reg     <= width_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        h_reg    <= h_next;
    end

    `LZWC_ASSERT_NOW(a_width_bounds, clk, rst_n, 1'b1,
        (width_reg >= lzwc_pkg::START_WIDTH) && (width_reg <= 5'(M)))
    `LZWC_ASSERT_NOW(a_push_has_room, clk, rst_n, op_valid, !op_full)

endmodule
`default_nettype wire

// ===== hw/rtl/lzwc_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "lzw_stream_compressor_macros.svh"
module lzwc_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire lzwc_pkg::code_op_t op,
    input  wire logic               op_empty,
    output logic                    op_pop,
    lzwc_out_if.source              out_ch
);

    lzwc_pkg::back_state_t state_reg, state_next;
    logic [31:0] acc_reg, acc_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        last_reg, last_next;
    logic        end_reg, end_next;
    logic        ov_reg, ov_next;
    logic [7:0]  ob_reg, ob_next;
    logic        ol_reg, ol_next;
    logic        od_reg, od_next;
    logic        can_emit;
    logic [31:0] masked;
    logic [5:0]  sh;

    assign can_emit     = !ov_reg || out_ch.ready;
    assign out_ch.valid = ov_reg;
    assign out_ch.out_byte    = ob_reg;
    assign out_ch.run_last    = ol_reg;
    assign out_ch.stream_done = od_reg;

    assign masked = 32'(op.value) & ((32'd1 << op.width) - 32'd1);
    assign sh     = 6'd32 - {1'b0, op.width} - cnt_reg;

    always_comb
    begin
        state_next = state_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        last_next  = last_reg;
        end_next   = end_reg;
        ov_next    = ov_reg && !out_ch.ready;
        ob_next    = ob_reg;
        ol_next    = ol_reg;
        od_next    = od_reg;
        op_pop     = 1'b0;
        case (state_reg)
            lzwc_pkg::B_LOAD:
            begin
                if (!op_empty)
                begin
                    op_pop     = 1'b1;
                    acc_next   = acc_reg | (masked << sh);
                    cnt_next   = cnt_reg + {1'b0, op.width};
                    last_next  = op.last;
                    end_next   = op.is_end;
                    state_next = lzwc_pkg::B_DRAIN;
                end
            end
            lzwc_pkg::B_DRAIN:
            begin
                if (cnt_reg < 6'd8)
                begin
                    state_next = end_reg ? lzwc_pkg::B_FLUSH1 : lzwc_pkg::B_LOAD;
                end
                else if (can_emit)
                begin
                    ov_next  = 1'b1;
                    ob_next  = acc_reg[31:24];
                    ol_next  = last_reg && !end_reg && (cnt_reg < 6'd16);
                    od_next  = 1'b0;
                    acc_next = acc_reg << 8;
                    cnt_next = cnt_reg - 6'd8;
                end
            end
            lzwc_pkg::B_FLUSH1:
            begin
                if (can_emit)
                begin
                    ov_next = 1'b1;
                    ob_next = acc_reg[31:24];
                    ol_next = (cnt_reg < 6'd4);
                    od_next = (cnt_reg < 6'd4);
                    if (cnt_reg < 6'd4)
                    begin
                        acc_next   = '0;
                        cnt_next   = '0;
                        state_next = lzwc_pkg::B_LOAD;
                    end
                    else
                    begin
                        state_next = lzwc_pkg::B_FLUSH2;
                    end
                end
            end
            lzwc_pkg::B_FLUSH2:
            begin
                if (can_emit)
                begin
                    ov_next    = 1'b1;
                    ob_next    = '0;
                    ol_next    = 1'b1;
                    od_next    = 1'b1;
                    acc_next   = '0;
                    cnt_next   = '0;
                    state_next = lzwc_pkg::B_LOAD;
                end
            end
            default:
            begin
                state_next = lzwc_pkg::B_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lzwc_pkg::B_LOAD;
            acc_reg   <= '0;
            cnt_reg   <= '0;
            last_reg  <= 1'b0;
            end_reg   <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            acc_reg   <= acc_next;
            cnt_reg   <= cnt_next;
            last_reg  <= last_next;
            end_reg   <= end_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ob_reg <= ob_next;
        ol_reg <= ol_next;
        od_reg <= od_next;
    end

    `LZWC_ASSERT_NOW(a_load_has_room, clk, rst_n,
        state_reg == lzwc_pkg::B_LOAD, cnt_reg < 6'd8)
    `LZWC_ASSERT_NOW(a_done_is_last, clk, rst_n, ov_reg && od_reg, ol_reg)

endmodule
`default_nettype wire
